[rtl/core/tcp_sender_window_control_defines.svh]
// Assertion macros for the sender window control block.
`ifndef TCP_SENDER_WINDOW_CONTROL_DEFINES_SVH
`define TCP_SENDER_WINDOW_CONTROL_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TSWC_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSWC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

[rtl/core/tswc_pkg.sv]
// Shared types and constants of the sender window control block.
package tswc_pkg;
   localparam int SegmentBytes = 1024;
   localparam int SeqSpace = 30720;
   localparam logic [15:0] SEG_BYTES = 16'd1024;
   localparam logic [15:0] SEQ_SPACE = 16'd30720;
   localparam logic [15:0] WIN_LIMIT = 16'((SeqSpace + 1) / 2);
   localparam logic [15:0] MINUS_ONE = 16'hFFFF;
   localparam logic [15:0] CWND_RESET = 16'd1024;
   localparam logic [15:0] SSTHRESH_RESET = 16'd15360;
   localparam logic [20:0] SEG_SQUARE = 21'(SegmentBytes * SegmentBytes);
   localparam logic [3:0] MAX_OUT = 4'd15;

   localparam logic [1:0] ACT_SYN = 2'd0;
   localparam logic [1:0] ACT_ACK = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;
   localparam logic [1:0] ACT_FINACK = 2'd3;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_SYN = 3'd1;
   localparam logic [2:0] PH_DATA = 3'd2;
   localparam logic [2:0] PH_FIN = 3'd3;
   localparam logic [2:0] PH_WAIT = 3'd4;
   localparam logic [2:0] PH_CLOSED = 3'd5;

   localparam logic [2:0] FLAG_NONE = 3'd0;
   localparam logic [2:0] FLAG_FIN = 3'd1;
   localparam logic [2:0] FLAG_SYN = 3'd2;
   localparam logic [2:0] FLAG_ACK = 3'd4;

   // Operations the controller asks of the datapath.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SYN,
      OP_ACK_UPDATE,
      OP_ACK_WINDOW,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_ACK_GROW,
      OP_FIN,
      OP_DATA_SEG,
      OP_TIMEOUT,
      OP_TIMEOUT_DATA,
      OP_WAIT,
      OP_FINACK
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [1:0] action;
      logic open;
      logic finack_ok;
      logic fin_ready;
      logic [3:0] seg_count;
      logic chunk_zero;
      logic div_done;
      logic rewind_empty;
      logic close_now;
   } status_type;

   function automatic logic [15:0] seq_mod(input logic [16:0] v);
      logic [16:0] r;
      r = v;
      if (r >= 17'(SEQ_SPACE)) r = r - 17'(SEQ_SPACE);
      if (r >= 17'(SEQ_SPACE)) r = r - 17'(SEQ_SPACE);
      return r[15:0];
   endfunction
endpackage

[rtl/core/tcp_sender_window_control.sv]
// Top level of the TCP sender window control block.
// An item is taken only when the block is idle; SYN, FIN-ACK and timeout items
// finish after decoding and the result handshake. An ACK item shows its first segment
// descriptor after the window update, the 21-step serial divider for the window growth
// and the growth step, then one per cycle while rsp_ready holds, up to fifteen.
// Synchronous active-high reset returns the connection to idle with default windows.
`include "tcp_sender_window_control_defines.svh"
module tcp_sender_window_control import tswc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_peer_seq,
   input  logic [15:0] req_peer_ack,
   input  logic [15:0] req_peer_window,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_seg_seq,
   output logic [15:0] rsp_seg_ack,
   output logic [13:0] rsp_seg_window,
   output logic [2:0]  rsp_seg_flags,
   output logic [10:0] rsp_seg_length,
   output logic [23:0] rsp_payload_offset,
   output logic        rsp_is_retransmit,
   output logic        rsp_close_done,
   output logic        rsp_last_of_run
);
   cmd_type    cmd;
   status_type status;
   logic       last_flag;

   tswc_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd, .last_flag
   );

   tswc_datapath u_datapath (
      .clock, .reset, .csr_write_enable, .csr_write_data, .cmd, .last_flag,
      .req_action, .req_peer_seq, .req_peer_ack, .req_peer_window, .status,
      .rsp_seg_seq, .rsp_seg_ack, .rsp_seg_window, .rsp_seg_flags, .rsp_seg_length,
      .rsp_payload_offset, .rsp_is_retransmit, .rsp_close_done, .rsp_last_of_run
   );

   `TSWC_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid, !req_ready)
   `TSWC_ASSERT_IMP(a_close_alone, clock, reset, rsp_valid && rsp_close_done,
                    rsp_last_of_run && rsp_seg_flags == FLAG_NONE)
   `TSWC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
endmodule

[rtl/core/tswc_datapath.sv]
// Datapath: connection state, window arithmetic, serial divider and result register.
module tswc_datapath import tswc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data,
   input  cmd_type     cmd,
   input  logic        last_flag,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_peer_seq,
   input  logic [15:0] req_peer_ack,
   input  logic [15:0] req_peer_window,
   output status_type  status,
   output logic [15:0] rsp_seg_seq,
   output logic [15:0] rsp_seg_ack,
   output logic [13:0] rsp_seg_window,
   output logic [2:0]  rsp_seg_flags,
   output logic [10:0] rsp_seg_length,
   output logic [23:0] rsp_payload_offset,
   output logic        rsp_is_retransmit,
   output logic        rsp_close_done,
   output logic        rsp_last_of_run
);
   logic [23:0] len_ff;
   logic [2:0]  phase_ff;
   logic [15:0] cwnd_ff, ssth_ff, lsent_ff, lacked_ff, echo_ff, finw_ff;
   logic [23:0] soff_ff, aoff_ff;
   logic        finsent_ff;
   logic [1:0]  quiet_ff;
   logic [1:0]  act_ff;
   logic [15:0] pseq_ff, pack_ff, pwin_ff;
   logic [15:0] win_ff, seq_ff, unack_ff;
   logic [3:0]  nseg_ff;
   logic [20:0] rem_ff;
   logic [15:0] quo_ff;
   logic [4:0]  dcnt_ff;
   logic [15:0] seq_o_ff, ack_o_ff;
   logic [13:0] win_o_ff;
   logic [2:0]  flg_o_ff;
   logic [10:0] len_o_ff;
   logic [23:0] off_o_ff;
   logic        retx_o_ff, done_o_ff;

   function automatic logic [15:0] sv_plus(input logic [15:0] x, input logic [15:0] d);
      // Sequence value plus d modulo the sequence space; minus one reads as -1.
      logic [16:0] t;
      if (x == MINUS_ONE) t = 17'(d) + 17'(SEQ_SPACE) - 17'd1;
      else t = 17'(x) + 17'(d);
      return seq_mod(t);
   endfunction

   logic [15:0] flight;
   logic [16:0] fdiff;
   logic [16:0] ls_val, la_val;
   logic [23:0] chunk_rem;
   logic [10:0] chunk_len;
   logic [15:0] min_w, adv_w, acked_n, pack_mod;
   logic [16:0] gro;
   logic [23:0] rewind;
   logic [20:0] rshift;
   logic [16:0] cc;

   always_comb begin
      ls_val = (lsent_ff == MINUS_ONE) ? 17'd0 : 17'(lsent_ff) + 17'd1;
      la_val = (lacked_ff == MINUS_ONE) ? 17'd0 : 17'(lacked_ff) + 17'd1;
      fdiff = ls_val + 17'(SEQ_SPACE) - la_val;
      flight = seq_mod(fdiff);
      min_w = pwin_ff;
      if (cwnd_ff < min_w) min_w = cwnd_ff;
      if (WIN_LIMIT < min_w) min_w = WIN_LIMIT;
      adv_w = (min_w > flight) ? min_w - flight : 16'd0;
      chunk_rem = len_ff - soff_ff;
      if (soff_ff >= len_ff) chunk_len = 11'd0;
      else if (chunk_rem < 24'(SEG_BYTES)) chunk_len = chunk_rem[10:0];
      else chunk_len = 11'(SEG_BYTES);
      pack_mod = seq_mod(17'(pack_ff));
      acked_n = (pack_mod == 16'd0) ? SEQ_SPACE - 16'd1 : pack_mod - 16'd1;
      rewind = (aoff_ff != 24'd0) ? aoff_ff - 24'd1 : 24'd0;
      rshift = {rem_ff[19:0], 1'b0};
      gro = 17'(cwnd_ff) + 17'(quo_ff);
      cc = (cwnd_ff < ssth_ff) ? 17'(cwnd_ff) + 17'(SEG_BYTES) : gro;
   end

   function automatic logic [13:0] sat_win(input logic [15:0] w);
      return (w > 16'd16383) ? 14'h3FFF : w[13:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 24'd0;
         phase_ff <= PH_IDLE;
         cwnd_ff <= CWND_RESET;
         ssth_ff <= SSTHRESH_RESET;
         lsent_ff <= MINUS_ONE;
         lacked_ff <= MINUS_ONE;
         soff_ff <= 24'd0;
         aoff_ff <= 24'd0;
         echo_ff <= 16'd0;
         finsent_ff <= 1'b0;
         quiet_ff <= 2'd0;
         finw_ff <= 16'd0;
      end else begin
         if (csr_write_enable) len_ff <= csr_write_data;
         unique case (cmd.op)
            OP_LOAD: begin
               act_ff <= req_action;
               pseq_ff <= req_peer_seq;
               pack_ff <= req_peer_ack;
               pwin_ff <= req_peer_window;
            end
            OP_SYN: begin
               phase_ff <= PH_SYN;
               echo_ff <= pseq_ff + 16'd1;
               seq_o_ff <= 16'd0;
               ack_o_ff <= pseq_ff + 16'd1;
               win_o_ff <= sat_win(adv_w);
               flg_o_ff <= FLAG_SYN | FLAG_ACK;
               len_o_ff <= 11'd0;
               off_o_ff <= 24'd0;
               retx_o_ff <= 1'b0;
               done_o_ff <= 1'b0;
               lsent_ff <= 16'd0;
            end
            OP_ACK_UPDATE: begin
               phase_ff <= PH_DATA;
               echo_ff <= pseq_ff;
               if (lacked_ff == MINUS_ONE) begin
                  aoff_ff <= aoff_ff + 24'(acked_n) + 24'd1;
                  lacked_ff <= acked_n;
               end else if (acked_n > lacked_ff) begin
                  aoff_ff <= aoff_ff + 24'(acked_n - lacked_ff);
                  lacked_ff <= acked_n;
               end else if (acked_n < lacked_ff && lacked_ff - acked_n > WIN_LIMIT) begin
                  aoff_ff <= aoff_ff + 24'(SEQ_SPACE - lacked_ff + acked_n);
                  lacked_ff <= acked_n;
               end
            end
            OP_ACK_WINDOW: begin
               unack_ff <= flight;
               seq_ff <= sv_plus(lsent_ff, 16'd1);
               win_ff <= adv_w;
               nseg_ff <= (adv_w[15:10] > 6'(MAX_OUT)) ? MAX_OUT : adv_w[13:10];
            end
            OP_DIV_START: begin
               rem_ff <= 21'd0;
               quo_ff <= 16'd0;
               dcnt_ff <= 5'd21;
            end
            OP_DIV_STEP: begin
               // One restoring step per cycle over the 21 dividend bits.
               logic [20:0] tr;
               tr = rshift | 21'(SEG_SQUARE[dcnt_ff - 5'd1]);
               if (tr >= 21'(cwnd_ff)) begin
                  rem_ff <= tr - 21'(cwnd_ff);
                  quo_ff <= {quo_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= tr;
                  quo_ff <= {quo_ff[14:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 5'd1;
            end
            OP_ACK_GROW: begin
               cwnd_ff <= (cc > 17'd65535) ? 16'hFFFF : cc[15:0];
            end
            OP_FIN: begin
               phase_ff <= PH_FIN;
               finsent_ff <= 1'b1;
               finw_ff <= win_ff;
               lsent_ff <= seq_ff;
               seq_o_ff <= seq_ff;
               ack_o_ff <= echo_ff;
               win_o_ff <= sat_win(win_ff);
               flg_o_ff <= FLAG_FIN;
               len_o_ff <= 11'd0;
               off_o_ff <= 24'd0;
               retx_o_ff <= 1'b0;
               done_o_ff <= 1'b0;
            end
            OP_DATA_SEG: begin
               seq_o_ff <= seq_ff;
               ack_o_ff <= echo_ff;
               win_o_ff <= sat_win(win_ff);
               flg_o_ff <= FLAG_ACK;
               len_o_ff <= chunk_len;
               off_o_ff <= soff_ff;
               retx_o_ff <= 1'b0;
               done_o_ff <= 1'b0;
               soff_ff <= soff_ff + 24'(chunk_len);
               seq_ff <= seq_mod(17'(seq_ff) + 17'(chunk_len));
               lsent_ff <= seq_mod(17'(seq_ff) + 17'(chunk_len) + 17'(SEQ_SPACE) - 17'd1);
               nseg_ff <= nseg_ff - 4'd1;
            end
            OP_TIMEOUT: begin
               ssth_ff <= (cwnd_ff[15:1] < SEG_BYTES[14:0]) ? SEG_BYTES : {1'b0, cwnd_ff[15:1]};
               cwnd_ff <= SEG_BYTES;
               seq_o_ff <= (phase_ff == PH_SYN) ? 16'd0 : sv_plus(lacked_ff, 16'd1);
               ack_o_ff <= echo_ff;
               win_o_ff <= sat_win(SEG_BYTES);
               len_o_ff <= 11'd0;
               off_o_ff <= 24'd0;
               done_o_ff <= 1'b0;
               if (phase_ff == PH_SYN) begin
                  flg_o_ff <= FLAG_SYN | FLAG_ACK;
                  retx_o_ff <= 1'b1;
                  lsent_ff <= 16'd0;
               end else if (phase_ff == PH_DATA) begin
                  soff_ff <= rewind;
               end else begin
                  flg_o_ff <= FLAG_FIN;
                  retx_o_ff <= finsent_ff;
                  finsent_ff <= 1'b1;
                  finw_ff <= SEG_BYTES;
                  lsent_ff <= sv_plus(lacked_ff, 16'd1);
               end
            end
            OP_TIMEOUT_DATA: begin
               if (chunk_len == 11'd0) begin
                  phase_ff <= PH_FIN;
               end else begin
                  flg_o_ff <= FLAG_ACK;
                  retx_o_ff <= 1'b1;
                  len_o_ff <= chunk_len;
                  off_o_ff <= soff_ff;
                  soff_ff <= soff_ff + 24'(chunk_len);
                  lsent_ff <= seq_mod(17'(seq_o_ff) + 17'(chunk_len) + 17'(SEQ_SPACE)
                                      - 17'd1);
               end
            end
            OP_WAIT: begin
               if (act_ff == ACT_FINACK) begin
                  quiet_ff <= 2'd0;
                  seq_o_ff <= sv_plus(lsent_ff, 16'd1);
                  ack_o_ff <= echo_ff;
                  win_o_ff <= sat_win(finw_ff);
                  flg_o_ff <= FLAG_ACK;
                  len_o_ff <= 11'd0;
                  off_o_ff <= 24'd0;
                  retx_o_ff <= 1'b0;
                  done_o_ff <= 1'b0;
               end else if (act_ff == ACT_TIMEOUT) begin
                  quiet_ff <= quiet_ff + 2'd1;
                  if (quiet_ff + 2'd1 >= 2'd2) begin
                     phase_ff <= PH_CLOSED;
                     seq_o_ff <= 16'd0;
                     ack_o_ff <= 16'd0;
                     win_o_ff <= 14'd0;
                     flg_o_ff <= FLAG_NONE;
                     len_o_ff <= 11'd0;
                     off_o_ff <= 24'd0;
                     retx_o_ff <= 1'b0;
                     done_o_ff <= 1'b1;
                  end
               end
            end
            OP_FINACK: begin
               echo_ff <= echo_ff + 16'd1;
               phase_ff <= PH_WAIT;
               quiet_ff <= 2'd0;
               seq_o_ff <= sv_plus(lsent_ff, 16'd1);
               ack_o_ff <= echo_ff + 16'd1;
               win_o_ff <= sat_win(finw_ff);
               flg_o_ff <= FLAG_ACK;
               len_o_ff <= 11'd0;
               off_o_ff <= 24'd0;
               retx_o_ff <= 1'b0;
               done_o_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.phase = phase_ff;
      status.action = act_ff;
      status.open = (phase_ff <= PH_DATA) || (phase_ff == PH_FIN && !finsent_ff);
      status.finack_ok = (phase_ff == PH_FIN) && finsent_ff && (pseq_ff == echo_ff);
      status.fin_ready = (soff_ff == len_ff) && (unack_ff == 16'd0);
      status.seg_count = nseg_ff;
      status.chunk_zero = (chunk_len == 11'd0);
      status.div_done = (dcnt_ff == 5'd0);
      status.rewind_empty = (chunk_len == 11'd0);
      status.close_now = (act_ff == ACT_TIMEOUT) && (quiet_ff + 2'd1 >= 2'd2);
   end

   assign rsp_seg_seq = seq_o_ff;
   assign rsp_seg_ack = ack_o_ff;
   assign rsp_seg_window = win_o_ff;
   assign rsp_seg_flags = flg_o_ff;
   assign rsp_seg_length = len_o_ff;
   assign rsp_payload_offset = off_o_ff;
   assign rsp_is_retransmit = retx_o_ff;
   assign rsp_close_done = done_o_ff;
   assign rsp_last_of_run = last_flag;
endmodule

[rtl/core/tswc_control.sv]
// Controller: event sequencing and the result handshake.
module tswc_control import tswc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       last_flag
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ACK_WIN, S_DIV_START, S_DIV, S_GROW, S_SEG, S_TO_DATA,
      S_OUT, S_OUT_SEG
   } state_type;

   state_type state_ff;
   logic rsp_valid_ff, last_ff;

   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) cmd.op = OP_LOAD;
         S_DECODE: begin
            if (status.phase == PH_WAIT) cmd.op = OP_WAIT;
            else if (status.phase <= PH_FIN) begin
               if (status.action == ACT_SYN && status.open) cmd.op = OP_SYN;
               else if (status.action == ACT_ACK && status.open) cmd.op = OP_ACK_UPDATE;
               else if (status.action == ACT_TIMEOUT && status.phase != PH_IDLE)
                  cmd.op = OP_TIMEOUT;
               else if (status.action == ACT_FINACK && status.finack_ok) cmd.op = OP_FINACK;
            end
         end
         S_ACK_WIN: cmd.op = OP_ACK_WINDOW;
         S_DIV_START: cmd.op = OP_DIV_START;
         S_DIV: if (!status.div_done) cmd.op = OP_DIV_STEP;
         S_GROW: cmd.op = OP_ACK_GROW;
         S_SEG: begin
            if (status.fin_ready) cmd.op = OP_FIN;
            else if (status.seg_count != 4'd0 && !status.chunk_zero) cmd.op = OP_DATA_SEG;
         end
         S_TO_DATA: cmd.op = OP_TIMEOUT_DATA;
         S_OUT_SEG: if (rsp_ready && status.seg_count != 4'd0 && !status.chunk_zero)
            cmd.op = OP_DATA_SEG;
         S_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_DECODE;
            S_DECODE: begin
               unique case (cmd.op)
                  OP_SYN, OP_FINACK: begin
                     rsp_valid_ff <= 1'b1; last_ff <= 1'b1; state_ff <= S_OUT;
                  end
                  OP_WAIT: begin
                     if (status.action == ACT_FINACK || status.close_now) begin
                        rsp_valid_ff <= 1'b1; last_ff <= 1'b1; state_ff <= S_OUT;
                     end else state_ff <= S_IDLE;
                  end
                  OP_ACK_UPDATE: state_ff <= S_ACK_WIN;
                  OP_TIMEOUT: begin
                     if (status.phase == PH_DATA) state_ff <= S_TO_DATA;
                     else begin
                        rsp_valid_ff <= 1'b1; last_ff <= 1'b1; state_ff <= S_OUT;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_ACK_WIN: state_ff <= S_DIV_START;
            S_DIV_START: state_ff <= S_DIV;
            S_DIV: if (status.div_done) state_ff <= S_GROW;
            S_GROW: state_ff <= S_SEG;
            S_SEG: begin
               if (cmd.op == OP_FIN) begin
                  rsp_valid_ff <= 1'b1; last_ff <= 1'b1; state_ff <= S_OUT;
               end else if (cmd.op == OP_DATA_SEG) begin
                  rsp_valid_ff <= 1'b1; last_ff <= 1'b0; state_ff <= S_OUT_SEG;
               end else state_ff <= S_IDLE;
            end
            S_OUT_SEG: begin
               // Next segment is computed in the cycle the current one leaves.
               if (rsp_ready) begin
                  if (cmd.op == OP_DATA_SEG) begin
                     rsp_valid_ff <= 1'b1; last_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b0; state_ff <= S_IDLE;
                  end
               end
            end
            S_TO_DATA: begin
               if (status.rewind_empty) state_ff <= S_IDLE;
               else begin
                  rsp_valid_ff <= 1'b1; last_ff <= 1'b1; state_ff <= S_OUT;
               end
            end
            S_OUT: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The last data segment is known only once the following one is ruled out.
   assign last_flag = (state_ff == S_OUT_SEG)
                      ? (status.seg_count == 4'd0 || status.chunk_zero) : last_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

[bench/tcp_sender_window_control_tb.sv]
// Self-checking testbench for the TCP sender window control block.
`timescale 1ns / 100ps
module tcp_sender_window_control_tb;
   import tswc_pkg::*;

   typedef struct packed {
      logic [15:0] seq;
      logic [15:0] ack;
      logic [13:0] win;
      logic [2:0]  flags;
      logic [10:0] len;
      logic [23:0] off;
      logic        retx;
      logic        done;
      logic        last;
   } seg_type;

   class segment_tracker_type;
      int phase, cwnd, ssth, lsent, lacked, soff, aoff;
      int echo, fin_sent, quiet, fin_win, xfer, errors;
      seg_type expected_segs[$];
      seg_type run[$];

      function new();
         phase = PH_IDLE;
         cwnd = CWND_RESET;
         ssth = SSTHRESH_RESET;
         lsent = MINUS_ONE;
         lacked = MINUS_ONE;
         soff = 0;
         aoff = 0;
         echo = 0;
         fin_sent = 0;
         quiet = 0;
         fin_win = 0;
         xfer = 0;
         errors = 0;
      endfunction

      function int sval(int x);
         return (x == 'hFFFF) ? -1 : x;
      endfunction

      function int smod(int v);
         int r;
         r = v % SeqSpace;
         if (r < 0) r += SeqSpace;
         return r;
      endfunction

      function int flight();
         return smod(sval(lsent) - sval(lacked));
      endfunction

      function int window(int peer, int unacked);
         int m;
         m = peer;
         if (cwnd < m) m = cwnd;
         if ((SeqSpace + 1) / 2 < m) m = (SeqSpace + 1) / 2;
         return (m > unacked) ? m - unacked : 0;
      endfunction

      function int chunk();
         int r;
         if (soff >= xfer) return 0;
         r = xfer - soff;
         return (r < SegmentBytes) ? r : SegmentBytes;
      endfunction

      function void emit(int seq, int ack, int wnd, logic [2:0] flags, int len, int off,
                         int retx, int done);
         seg_type s;
         s.seq = seq[15:0];
         s.ack = ack[15:0];
         s.win = (wnd > 16383) ? 14'd16383 : wnd[13:0];
         s.flags = flags;
         s.len = len[10:0];
         s.off = off[23:0];
         s.retx = retx[0];
         s.done = done[0];
         s.last = 1'b0;
         run.push_back(s);
      endfunction

      function void grow();
         int c;
         c = (cwnd != 0) ? cwnd : 1;
         if (cwnd < ssth) c = cwnd + SegmentBytes;
         else c = cwnd + (SegmentBytes * SegmentBytes) / c;
         cwnd = (c > 65535) ? 65535 : c;
      endfunction

      function void on_syn(int pseq, int pwin);
         int w;
         w = window(pwin, flight());
         phase = PH_SYN;
         echo = (pseq + 1) & 'hFFFF;
         emit(0, echo, w, FLAG_SYN | FLAG_ACK, 0, 0, 0, 0);
         lsent = 0;
      endfunction

      function void on_ack(int pseq, int pack, int pwin);
         int a, acked, la, unacked, seq, w, n, b;
         a = pack % SeqSpace;
         acked = (a == 0) ? SeqSpace - 1 : a - 1;
         la = sval(lacked);
         phase = PH_DATA;
         if (acked > la) begin
            aoff = (aoff + acked - la) & 'hFFFFFF;
            lacked = acked;
         end else if (acked < la && la - acked > (SeqSpace + 1) / 2) begin
            aoff = (aoff + SeqSpace - la + acked) & 'hFFFFFF;
            lacked = acked;
         end
         unacked = flight();
         seq = smod(sval(lsent) + 1);
         echo = pseq;
         w = window(pwin, unacked);
         grow();
         if (soff == xfer && unacked == 0) begin
            phase = PH_FIN;
            fin_sent = 1;
            fin_win = w;
            lsent = seq;
            emit(seq, echo, w, FLAG_FIN, 0, 0, 0, 0);
            return;
         end
         n = w / SegmentBytes;
         if (n > MAX_OUT) n = MAX_OUT;
         for (int i = 0; i < n; i++) begin
            b = chunk();
            if (b == 0) break;
            emit(seq, echo, w, FLAG_ACK, b, soff, 0, 0);
            soff = (soff + b) & 'hFFFFFF;
            seq = smod(seq + b);
            lsent = smod(seq - 1);
         end
      endfunction

      function void on_timeout();
         int seq, b;
         ssth = cwnd / 2;
         if (ssth < SegmentBytes) ssth = SegmentBytes;
         cwnd = SegmentBytes;
         if (phase == PH_SYN) begin
            emit(0, echo, cwnd, FLAG_SYN | FLAG_ACK, 0, 0, 1, 0);
            lsent = 0;
            return;
         end
         if (phase == PH_DATA) begin
            soff = (aoff != 0) ? aoff - 1 : 0;
            b = chunk();
            if (b == 0) begin
               phase = PH_FIN;
               return;
            end
            seq = smod(sval(lacked) + 1);
            emit(seq, echo, cwnd, FLAG_ACK, b, soff, 1, 0);
            soff = (soff + b) & 'hFFFFFF;
            lsent = smod(seq + b - 1);
            return;
         end
         seq = smod(sval(lacked) + 1);
         emit(seq, echo, cwnd, FLAG_FIN, 0, 0, fin_sent, 0);
         fin_sent = 1;
         fin_win = cwnd;
         lsent = seq;
      endfunction

      function int note_event(logic [1:0] act, int pseq, int pack, int pwin);
         bit open;
         run.delete();
         open = phase <= PH_DATA || (phase == PH_FIN && !fin_sent);
         if (phase == PH_WAIT) begin
            if (act == ACT_FINACK) begin
               quiet = 0;
               emit(smod(sval(lsent) + 1), echo, fin_win, FLAG_ACK, 0, 0, 0, 0);
            end else if (act == ACT_TIMEOUT) begin
               quiet = (quiet + 1) & 3;
               if (quiet >= 2) begin
                  phase = PH_CLOSED;
                  emit(0, 0, 0, FLAG_NONE, 0, 0, 0, 1);
               end
            end
         end else if (phase <= PH_FIN) begin
            if (act == ACT_SYN && open) on_syn(pseq, pwin);
            else if (act == ACT_ACK && open) on_ack(pseq, pack, pwin);
            else if (act == ACT_TIMEOUT && phase != PH_IDLE) on_timeout();
            else if (act == ACT_FINACK && phase == PH_FIN && fin_sent && pseq == echo) begin
               echo = (echo + 1) & 'hFFFF;
               phase = PH_WAIT;
               quiet = 0;
               emit(smod(sval(lsent) + 1), echo, fin_win, FLAG_ACK, 0, 0, 0, 0);
            end
         end
         if (run.size() > 0) run[run.size() - 1].last = 1'b1;
         foreach (run[i]) expected_segs.push_back(run[i]);
         return run.size();
      endfunction

      function void compare(string name, longint e, longint a);
         if (e != a) begin
            $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_segment(seg_type got);
         seg_type e;
         if (expected_segs.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_segs.pop_front();
         compare("seg_seq", e.seq, got.seq);
         compare("seg_ack", e.ack, got.ack);
         compare("seg_window", e.win, got.win);
         compare("seg_flags", e.flags, got.flags);
         compare("seg_length", e.len, got.len);
         compare("payload_offset", e.off, got.off);
         compare("is_retransmit", e.retx, got.retx);
         compare("close_done", e.done, got.done);
         compare("last_of_run", e.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [23:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_SYN;
   logic [15:0] req_peer_seq = '0;
   logic [15:0] req_peer_ack = '0;
   logic [15:0] req_peer_window = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_seg_seq;
   logic [15:0] rsp_seg_ack;
   logic [13:0] rsp_seg_window;
   logic [2:0]  rsp_seg_flags;
   logic [10:0] rsp_seg_length;
   logic [23:0] rsp_payload_offset;
   logic        rsp_is_retransmit;
   logic        rsp_close_done;
   logic        rsp_last_of_run;

   segment_tracker_type trk = new();
   bit idling = 1'b1;

   tcp_sender_window_control dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : rsp_side
      seg_type got;
      bit fire;
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         fire = rsp_valid && rsp_ready;
         got = '{rsp_seg_seq, rsp_seg_ack, rsp_seg_window, rsp_seg_flags, rsp_seg_length,
                 rsp_payload_offset, rsp_is_retransmit, rsp_close_done, rsp_last_of_run};
         @(posedge clock);
         if (fire) trk.check_segment(got);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_event(logic [1:0] act, logic [15:0] pseq, logic [15:0] pack,
                             logic [15:0] pwin);
      bit rdy;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_peer_seq <= pseq;
      req_peer_ack <= pack;
      req_peer_window <= pwin;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      void'(trk.note_event(act, int'(pseq), int'(pack), int'(pwin)));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (trk.expected_segs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_length(logic [23:0] len);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      trk.xfer = int'(len);
   endtask

   task automatic random_event();
      int r, pack, pwin;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 6) pwin = 16'hFFFF;
      else if ($urandom_range(0, 9) == 0) pwin = $urandom_range(0, 1023);
      else pwin = $urandom_range(0, 65535);
      if (trk.sval(trk.lacked) >= 0 && $urandom_range(0, 9) != 0)
         pack = trk.smod(trk.sval(trk.lacked) + 1 + $urandom_range(0, trk.flight()));
      else
         pack = $urandom_range(0, 65535);
      if (trk.phase == PH_IDLE ? r < 80 : r < 3)
         send_event(ACT_SYN, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'(pwin));
      else if (r < 14 && trk.phase != PH_WAIT)
         send_event(ACT_TIMEOUT, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'(pwin));
      else if (r < 18)
         send_event(ACT_FINACK, 16'(trk.phase == PH_WAIT ? trk.echo : trk.echo ^ 'h0001),
                    16'($urandom_range(0, 65535)), 16'(pwin));
      else
         send_event(ACT_ACK, 16'($urandom_range(0, 65535)), 16'(pack), 16'(pwin));
   endtask

   initial begin : stimulus
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_length(24'd3000);
      send_event(ACT_FINACK, 16'd0, 16'd0, 16'd0);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_SYN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_SYN, 16'd0, 16'd0, 16'd0);
      send_event(ACT_ACK, 16'h1234, 16'd1, 16'hFFFF);
      send_event(ACT_ACK, 16'h1234, 16'd1025, 16'd0);
      send_event(ACT_ACK, 16'h1234, 16'd1025, 16'hFFFF);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_ACK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_event(ACT_ACK, 16'd7, 16'd0, 16'hFFFF);
      send_event(ACT_FINACK, 16'd7, 16'd0, 16'd0);

      for (int ph = 0; ph < 10; ph++) begin
         idling = (ph % 3 != 2);
         if (trk.phase == PH_DATA || trk.phase == PH_SYN || trk.phase == PH_IDLE ||
             ph == 2 || ph == 5) begin
            if (ph == 2) len = 0;
            else if (ph == 5) len = 24'hFFFFFF;
            else if ($urandom_range(0, 5) == 0) len = trk.soff + $urandom_range(1, 1500);
            else len = trk.soff + $urandom_range(1, 300000);
            set_length(24'(len & 'hFFFFFF));
         end else begin
            drain();
         end
         repeat (30) random_event();
      end

      idling = 1'b0;
      if (!trk.fin_sent) begin
         set_length(24'(trk.soff + $urandom_range(0, 5000)));
         for (int i = 0; i < 300 && !trk.fin_sent; i++)
            send_event(ACT_ACK, 16'h0042, 16'(trk.smod(trk.sval(trk.lsent) + 1)), 16'hFFFF);
      end
      if (trk.phase == PH_FIN) begin
         send_event(ACT_FINACK, 16'(trk.echo ^ 'h8000), 16'd0, 16'd0);
         send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
         send_event(ACT_FINACK, 16'(trk.echo), 16'd0, 16'd0);
      end
      send_event(ACT_FINACK, 16'(trk.echo), 16'd0, 16'd0);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_FINACK, 16'd0, 16'd0, 16'd0);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0);
      send_event(ACT_SYN, 16'd5, 16'd0, 16'hFFFF);
      send_event(ACT_ACK, 16'd5, 16'd1, 16'hFFFF);
      drain();

      if (trk.errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/tswc_pkg.sv
rtl/core/tswc_datapath.sv
rtl/core/tswc_control.sv
rtl/core/tcp_sender_window_control.sv
bench/tcp_sender_window_control_tb.sv
